>>> sv/assert_macros.svh
// Assertion macros for the checker file of the walker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/llsdw_pkg.sv
// Package of the linked-list DMA walker: widths, block offsets and link codes,
// register indexes, action codes, result kinds. No dependencies.
package llsdw_pkg;

   localparam int ADDRESS_BITS  = 24;
   localparam int ADDR_OUT_BITS = 24;
   localparam int INDEX_BITS    = 23;

   localparam logic [31:0] OFS_NEXT     = 32'h1C;
   localparam logic [31:0] OFS_SIZE     = 32'h18;
   localparam logic [31:0] BLOCK_BYTES  = 32'd32;
   localparam logic [31:0] END_LINK     = 32'd2;
   localparam logic [31:0] RESTART_LINK = 32'd1;

   localparam logic [1:0] REG_LINK_BASE   = 2'd0;
   localparam logic [1:0] REG_TABLE_ADDR  = 2'd1;
   localparam logic [1:0] REG_TABLE_WIDE  = 2'd2;
   localparam logic [1:0] REG_LINK_SCALED = 2'd3;

   localparam logic ACTION_START    = 1'b0;
   localparam logic ACTION_RESPONSE = 1'b1;

   typedef enum logic [1:0] {
      KIND_READ = 2'd0,
      KIND_XFER = 2'd1,
      KIND_DONE = 2'd2
   } kind_type;

endpackage

>>> sv/linked_list_sort_dma_walker.sv
// Top level of the linked-list DMA walker: state, per-item logic, result queue.
// Depends on llsdw_pkg.

// The walker takes one transaction per cycle on req_ while its four-entry result
// queue has at least two free slots; each item is fully handled in the cycle it is
// accepted, and its results are registered into the queue. Results leave at one
// per cycle while rsp_tready is high, so a size response (a transfer plus the
// following read or done) puts two results on the output; with rsp_tready held
// high the sustained rate is one item per cycle for single-result items.
// req_tuser is the action (0 start, 1 read response); reads are issued as rsp_
// results of kind 0 and their data must come back as response items, in order.
module linked_list_sort_dma_walker
   import llsdw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] read_data
   input  logic        req_tuser,  // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,  // [23:0] address, [24] read_wide,
                                   // [56:25] transfer_size, [80:57] table_address_now
   output logic [1:0]  rsp_tuser,  // [1:0] kind
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam int AW = ADDRESS_BITS;

   typedef enum logic [3:0] {
      PH_IDLE       = 4'b0001,
      PH_START_LINK = 4'b0010,
      PH_NEXT_LINK  = 4'b0100,
      PH_SIZE       = 4'b1000
   } phase_type;

   typedef struct packed {
      kind_type                   kind;
      logic [ADDR_OUT_BITS-1:0]   address;
      logic                       read_wide;
      logic [31:0]                size;
      logic [23:0]                table_now;
      logic                       last;
   } rsp_type;

   // configuration
   logic [23:0] link_base_ff;
   logic        table_wide_ff;
   logic        link_scaled_ff;

   // walk state
   phase_type               phase_ff, phase_in;
   logic [INDEX_BITS-1:0]   start_index_ff, start_index_in;
   logic [AW-1:0]           block_ff, block_in;
   logic [31:0]             next_link_ff, next_link_in;
   logic [23:0]             rta_ff, rta_in;

   // result queue
   rsp_type     fifo_ff [4];
   logic [1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [2:0]  count_ff;

   logic        accept, pop;
   logic [1:0]  n_res;
   rsp_type     res0, res1, head;

   // start-link request
   logic [INDEX_BITS-1:0]   idx_sel;
   logic [INDEX_BITS+1:0]   ask_ofs;
   logic [AW-1:0]           ask_addr;
   rsp_type                 ask_res;

   // link following
   logic [31:0]  link_sel, link_ofs;
   logic [AW-1:0] fol_block, fol_next_addr;
   logic         fol_end;
   logic [23:0]  rta_plus;
   rsp_type      fol_res;
   logic [AW-1:0] size_addr;

   assign req_tready = (count_ff <= 3'd2);
   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   always_comb begin
      idx_sel = (phase_ff == PH_IDLE) ? '0 : start_index_ff;
      ask_ofs = table_wide_ff ? {idx_sel, 2'b00} : {1'b0, idx_sel, 1'b0};
      ask_addr = AW'(rta_ff) + AW'(ask_ofs);
      ask_res.kind      = KIND_READ;
      ask_res.address   = ADDR_OUT_BITS'(ask_addr);
      ask_res.read_wide = table_wide_ff;
      ask_res.size      = '0;
      ask_res.table_now = rta_ff;
      ask_res.last      = 1'b0;
   end

   always_comb begin
      if (phase_ff == PH_START_LINK) begin
         link_sel = table_wide_ff ? req_tdata : {16'h0000, req_tdata[15:0]};
      end else begin
         link_sel = next_link_ff;
      end
      link_ofs = link_scaled_ff ? {link_sel[26:0], 5'b00000} : {link_sel[31:5], 5'b00000};
      fol_block     = AW'(link_base_ff) + link_ofs[AW-1:0];
      fol_next_addr = fol_block + OFS_NEXT[AW-1:0];
      fol_end       = (link_sel == END_LINK);
      rta_plus      = rta_ff + BLOCK_BYTES[23:0];
      if (fol_end) begin
         fol_res.kind      = KIND_DONE;
         fol_res.address   = '0;
         fol_res.read_wide = 1'b0;
         fol_res.table_now = rta_plus;
      end else begin
         fol_res.kind      = KIND_READ;
         fol_res.address   = ADDR_OUT_BITS'(fol_next_addr);
         fol_res.read_wide = 1'b1;
         fol_res.table_now = rta_ff;
      end
      fol_res.size = '0;
      fol_res.last = 1'b0;
      size_addr    = block_ff + OFS_SIZE[AW-1:0];
   end

   always_comb begin
      phase_in       = phase_ff;
      start_index_in = start_index_ff;
      block_in       = block_ff;
      next_link_in   = next_link_ff;
      rta_in         = rta_ff;
      n_res          = 2'd0;
      res0           = ask_res;
      res1           = fol_res;
      if (accept) begin
         if (req_tuser == ACTION_START) begin
            if (phase_ff == PH_IDLE) begin
               res0           = ask_res;
               start_index_in = idx_sel + INDEX_BITS'(1);
               phase_in       = PH_START_LINK;
               n_res          = 2'd1;
            end
         end else begin
            case (phase_ff)
               PH_START_LINK: begin
                  res0  = fol_res;
                  n_res = 2'd1;
                  if (fol_end) begin
                     rta_in   = rta_plus;
                     phase_in = PH_IDLE;
                  end else begin
                     block_in = fol_block;
                     phase_in = PH_NEXT_LINK;
                  end
               end
               PH_NEXT_LINK: begin
                  next_link_in      = req_tdata;
                  phase_in          = PH_SIZE;
                  res0.kind         = KIND_READ;
                  res0.address      = ADDR_OUT_BITS'(size_addr);
                  res0.read_wide    = 1'b1;
                  res0.size         = '0;
                  res0.table_now    = rta_ff;
                  n_res             = 2'd1;
               end
               PH_SIZE: begin
                  res0.kind      = KIND_XFER;
                  res0.address   = ADDR_OUT_BITS'(block_ff);
                  res0.read_wide = 1'b0;
                  res0.size      = req_tdata;
                  res0.table_now = rta_ff;
                  n_res          = 2'd2;
                  if (next_link_ff == RESTART_LINK) begin
                     res1           = ask_res;
                     start_index_in = idx_sel + INDEX_BITS'(1);
                     phase_in       = PH_START_LINK;
                  end else begin
                     res1 = fol_res;
                     if (fol_end) begin
                        rta_in   = rta_plus;
                        phase_in = PH_IDLE;
                     end else begin
                        block_in = fol_block;
                        phase_in = PH_NEXT_LINK;
                     end
                  end
               end
               default: begin
                  // response while idle: drop
                  n_res = 2'd0;
               end
            endcase
         end
      end
      res0.last = (n_res == 2'd1);
      res1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_base_ff   <= '0;
         table_wide_ff  <= 1'b0;
         link_scaled_ff <= 1'b0;
         phase_ff       <= PH_IDLE;
         start_index_ff <= '0;
         block_ff       <= '0;
         next_link_ff   <= '0;
         rta_ff         <= '0;
      end else begin
         phase_ff       <= phase_in;
         start_index_ff <= start_index_in;
         block_ff       <= block_in;
         next_link_ff   <= next_link_in;
         rta_ff         <= rta_in;
         if (csr_wen) begin
            case (csr_index)
               REG_LINK_BASE:   link_base_ff   <= csr_wdata;
               REG_TABLE_ADDR:  rta_ff         <= csr_wdata;
               REG_TABLE_WIDE:  table_wide_ff  <= csr_wdata[0];
               REG_LINK_SCALED: link_scaled_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // queue storage: up to two entries written per accepted transaction
   always_ff @(posedge clock) begin
      if (n_res != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (n_res == 2'd2) begin
         fifo_ff[wr_ptr_ff + 2'd1] <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + n_res;
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_ff + {1'b0, n_res} - {2'b00, pop};
      end
   end

   assign head       = fifo_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {7'b0000000, head.table_now, head.size, head.read_wide, head.address};

endmodule

>>> sv/llsdw_checker.sv
// Port-level checker of the linked-list DMA walker, bound to the top level.
// Depends on llsdw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module llsdw_checker
   import llsdw_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled result transaction holds
   `ASSERT_RST(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "stalled result changed")

   // done always closes the results of its item
   `ASSERT_RST(a_done_last, clock, reset,
      rsp_tvalid && rsp_tuser == KIND_DONE |-> rsp_tlast,
      "done result not marked last")

   // a transfer is never marked last or wide: a read or a done of the same item follows it
   `ASSERT_RST(a_xfer_not_last, clock, reset,
      rsp_tvalid && rsp_tuser == KIND_XFER |-> !rsp_tlast && !rsp_tdata[24],
      "transfer marked last or wide")

   // queue is empty right after reset
   `ASSERT_ALWAYS(a_reset_empty, clock, !reset && $past(reset) |-> !rsp_tvalid,
      "result pending after reset")

endmodule

bind linked_list_sort_dma_walker llsdw_checker u_llsdw_checker (.*);
